### rtl/ucd_pkg.sv
// Shared constants and state encoding for the undirected cycle detector.
// No dependencies; imported by the top level.
package ucd_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VTX_W + 1;
	localparam int MAX_EDGES    = 4096;
	localparam int SLOT_TOTAL   = 2 * MAX_EDGES;
	localparam int SLOT_W       = $clog2(SLOT_TOTAL);
	localparam int HEAD_W       = SLOT_W + 1;
	localparam int LINK_W       = VTX_W + HEAD_W;

	localparam logic [HEAD_W-1:0] EMPTY_SLOT = HEAD_W'(SLOT_TOTAL);
	localparam logic [VCNT_W-1:0] NO_PARENT  = VCNT_W'(MAX_VERTICES);
	localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(MAX_VERTICES);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_CLEAR  = 15'b000000000000010,
		ST_LD_RA  = 15'b000000000000100,
		ST_LD_WA  = 15'b000000000001000,
		ST_LD_RB  = 15'b000000000010000,
		ST_LD_WB  = 15'b000000000100000,
		ST_SC_RD  = 15'b000000001000000,
		ST_SC_CHK = 15'b000000010000000,
		ST_Q_RD   = 15'b000000100000000,
		ST_Q_WAIT = 15'b000001000000000,
		ST_H_WAIT = 15'b000010000000000,
		ST_S_RD   = 15'b000100000000000,
		ST_S_WAIT = 15'b001000000000000,
		ST_N_CHK  = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} ucd_state_t;

endpackage

### rtl/ucd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ucd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/undirected_cycle_detect_bfs.sv
// Undirected cycle detector: edges go into linked adjacency lists, last edge starts a BFS.
// Depends on ucd_pkg and ucd_ram.
// A stored edge is accepted, then each head pointer gets a read-modify-write;
// a dropped edge is only accepted. After the last edge the vertices are scanned for roots,
// each root is searched breadth-first over its adjacency slots, then the done strobe.
// Reset and every answer start a clear of head and seen RAMs (busy high); no stall.
module undirected_cycle_detect_bfs
	import ucd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [VTX_W-1:0]  end_a,
	input  logic [VTX_W-1:0]  end_b,
	input  logic              last_edge,
	input  logic              cfg_we,
	input  logic [VCNT_W-1:0] cfg_wdata,
	output logic              done,
	output logic              cycle_found,
	output logic              edge_dropped
);

	ucd_state_t state_q;
	logic [VTX_W-1:0]  a_q, b_q, cur_q, nb_q, clr_q;
	logic              last_q, drop_q, cyc_q;
	logic [VCNT_W-1:0] vc_q, v_q, rd_q, wr_q, par_q;
	logic [HEAD_W-1:0] cnt_q, s_q, nxt_q;
	logic [VCNT_W-1:0] nv;

	// RAM ports
	logic              head_we, seen_we, par_we, q_we, slot_we;
	logic [VTX_W-1:0]  head_wa, head_ra, seen_wa, seen_ra, par_wa, par_ra, q_wa, q_ra;
	logic [HEAD_W-1:0] head_wd, head_rd;
	logic              seen_wd, seen_rd;
	logic [VCNT_W-1:0] par_wd, par_rd;
	logic [VTX_W-1:0]  q_wd, q_rd;
	logic [SLOT_W-1:0] slot_wa, slot_ra;
	logic [LINK_W-1:0] slot_wd, slot_rd;

	assign nv = (vc_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc_q;

	ucd_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(head_ra), .rdata(head_rd));
	ucd_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_TOTAL)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
		.raddr(slot_ra), .rdata(slot_rd));
	ucd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_seen (
		.clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd),
		.raddr(seen_ra), .rdata(seen_rd));
	ucd_ram #(.WIDTH(VCNT_W), .DEPTH(MAX_VERTICES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
		.raddr(par_ra), .rdata(par_rd));
	ucd_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.raddr(q_ra), .rdata(q_rd));

	// memory port steering per state
	always_comb begin
		head_we = 1'b0;
		head_wa = a_q;
		head_wd = cnt_q;
		head_ra = a_q;
		slot_we = 1'b0;
		slot_wa = cnt_q[SLOT_W-1:0];
		slot_wd = {b_q, head_rd};
		slot_ra = s_q[SLOT_W-1:0];
		seen_we = 1'b0;
		seen_wa = nb_q;
		seen_wd = 1'b1;
		seen_ra = slot_rd[LINK_W-1:HEAD_W];
		par_we  = 1'b0;
		par_wa  = nb_q;
		par_wd  = {1'b0, cur_q};
		par_ra  = q_rd;
		q_we    = 1'b0;
		q_wa    = wr_q[VTX_W-1:0];
		q_wd    = nb_q;
		q_ra    = rd_q[VTX_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
				head_wd = EMPTY_SLOT;
				seen_we = 1'b1;
				seen_wa = clr_q;
				seen_wd = 1'b0;
			end
			ST_LD_RA: head_ra = a_q;
			ST_LD_WA: begin
				head_we = 1'b1;
				slot_we = 1'b1;
			end
			ST_LD_RB: head_ra = b_q;
			ST_LD_WB: begin
				head_we = 1'b1;
				head_wa = b_q;
				slot_we = 1'b1;
				slot_wd = {a_q, head_rd};
			end
			ST_SC_RD: seen_ra = v_q[VTX_W-1:0];
			ST_SC_CHK: begin
				// new root: mark, no parent, queue slot zero
				seen_we = ~seen_rd;
				seen_wa = v_q[VTX_W-1:0];
				par_we  = ~seen_rd;
				par_wa  = v_q[VTX_W-1:0];
				par_wd  = NO_PARENT;
				q_we    = ~seen_rd;
				q_wa    = '0;
				q_wd    = v_q[VTX_W-1:0];
			end
			ST_Q_WAIT: head_ra = q_rd;
			ST_N_CHK: begin
				seen_we = ~seen_rd;
				par_we  = ~seen_rd;
				q_we    = ~seen_rd;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			vc_q    <= VCNT_RESET;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			cyc_q   <= 1'b0;
			v_q     <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			last_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			cur_q   <= '0;
			nb_q    <= '0;
			par_q   <= '0;
			s_q     <= '0;
			nxt_q   <= '0;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VTX_W'(MAX_VERTICES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						a_q    <= end_a;
						b_q    <= end_b;
						last_q <= last_edge;
						v_q    <= '0;
						if ({1'b0, end_a} >= nv || {1'b0, end_b} >= nv ||
						    cnt_q > HEAD_W'(SLOT_TOTAL - 2)) begin
							drop_q  <= 1'b1;
							state_q <= last_edge ? ST_SC_RD : ST_IDLE;
						end else begin
							state_q <= ST_LD_RA;
						end
					end
				end
				ST_LD_RA: state_q <= ST_LD_WA;
				ST_LD_WA: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= ST_LD_RB;
				end
				ST_LD_RB: state_q <= ST_LD_WB;
				ST_LD_WB: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= last_q ? ST_SC_RD : ST_IDLE;
				end
				ST_SC_RD: begin
					state_q <= (v_q == nv) ? ST_DONE : ST_SC_CHK;
				end
				ST_SC_CHK: begin
					if (seen_rd) begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_SC_RD;
					end else begin
						rd_q    <= '0;
						wr_q    <= VCNT_W'(1);
						state_q <= ST_Q_RD;
					end
				end
				ST_Q_RD: begin
					if (rd_q == wr_q) begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_SC_RD;
					end else begin
						rd_q    <= rd_q + 1'b1;
						state_q <= ST_Q_WAIT;
					end
				end
				ST_Q_WAIT: begin
					cur_q   <= q_rd;
					state_q <= ST_H_WAIT;
				end
				ST_H_WAIT: begin
					s_q     <= head_rd;
					par_q   <= par_rd;
					state_q <= ST_S_RD;
				end
				ST_S_RD: begin
					// end-of-list marker has the top bit set
					state_q <= s_q[SLOT_W] ? ST_Q_RD : ST_S_WAIT;
				end
				ST_S_WAIT: begin
					nb_q    <= slot_rd[LINK_W-1:HEAD_W];
					nxt_q   <= slot_rd[HEAD_W-1:0];
					state_q <= ST_N_CHK;
				end
				ST_N_CHK: begin
					if (seen_rd && {1'b0, nb_q} != par_q) begin
						cyc_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						if (!seen_rd) begin
							wr_q <= wr_q + 1'b1;
						end
						s_q     <= nxt_q;
						state_q <= ST_S_RD;
					end
				end
				ST_DONE: begin
					cnt_q   <= '0;
					drop_q  <= 1'b0;
					cyc_q   <= 1'b0;
					clr_q   <= '0;
					state_q <= ST_CLEAR;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_DONE);
	assign cycle_found  = cyc_q;
	assign edge_dropped = drop_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (busy && cnt_q == '0 && !drop_q)) else $error("graph not cleared");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HEAD_W'(SLOT_TOTAL)) else $error("slot count overflow");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= wr_q) else $error("queue read overtakes write");

endmodule
